// ===== rtl/indexed_list_store_top_assert.svh =====
// Assertion macros for the indexed list store.
`ifndef INDEXED_LIST_STORE_TOP_ASSERT_SVH
`define INDEXED_LIST_STORE_TOP_ASSERT_SVH

// Check a property on every rising edge of clk, skipped while rst is high.
`define ILS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, with a next-cycle implication built in.
`define ILS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/ils_pkg.sv =====
`timescale 1ns / 1ps

package ils_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 10;
  // Wide enough for a position or length up to the largest capacity (1024).
  localparam int unsigned SLOT_W = 11;

  localparam logic [2:0] ACT_READ   = 3'd0;
  localparam logic [2:0] ACT_FRONT  = 3'd1;
  localparam logic [2:0] ACT_BACK   = 3'd2;
  localparam logic [2:0] ACT_AT     = 3'd3;
  localparam logic [2:0] ACT_DELETE = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [DATA_W-1:0] READ_MISS = -32'sd1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_GATHER
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_state_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [SLOT_W-1:0]        pos;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/ils_if.sv =====
`timescale 1ns / 1ps

interface ils_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [9:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output action, output position, output value, input ready);
  modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface ils_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [1:0]         status;
  logic [6:0]         length_now;

  modport source (output valid, output read_value, output status, output length_now,
                  input ready);
  modport sink   (input valid, input read_value, input status, input length_now,
                  output ready);
endinterface

// ===== rtl/ils_cell.sv =====
`timescale 1ns / 1ps

module ils_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                               clk,
  input  ils_pkg::cell_ctrl_t                ctrl,
  input  logic signed [ils_pkg::DATA_W-1:0]  left,
  input  logic signed [ils_pkg::DATA_W-1:0]  right,
  output logic signed [ils_pkg::DATA_W-1:0]  entry,
  output logic signed [ils_pkg::DATA_W-1:0]  gathered
);

  localparam logic [ils_pkg::SLOT_W-1:0] MY_SLOT = ils_pkg::SLOT_W'(IDX);

  logic signed [ils_pkg::DATA_W-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      ils_pkg::CELL_INSERT: begin
        // Shift right behind the insert point, load the new value at it.
        if (MY_SLOT > ctrl.pos) begin
          entry_next = left;
        end else if (MY_SLOT == ctrl.pos) begin
          entry_next = ctrl.value;
        end
      end
      ils_pkg::CELL_DELETE: begin
        if (MY_SLOT >= ctrl.pos) begin
          entry_next = right;
        end
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry    <= entry_next;
    gathered <= (ctrl.op == ils_pkg::CELL_GATHER && ctrl.pos == MY_SLOT) ? entry : '0;
  end

endmodule

// ===== rtl/indexed_list_store_top.sv =====
`timescale 1ns / 1ps
// Indexed list store: an ordered list of up to CAPACITY signed 32-bit values.
// req (sink) takes one item: action, position, value. rsp (source) returns one
// item per request: read_value, status, length_now.
// Inserts and deletes move every entry behind the position by one place
// through a row of cells, one entry per cell; their result is registered and
// valid the cycle after acceptance. A read in range first has each cell
// register its entry if it sits at the position; then the registered words
// are OR-combined into the result register. Out-of-range reads and deletes,
// refused inserts and unknown actions answer like an insert, in the cycle
// after acceptance.
// req.ready is high only when no read is being gathered and the result
// register is empty or being emptied in the same cycle; while rsp is stalled
// the result holds and no new request is taken.
// Reset (rst, synchronous, active high) empties the list and drops any
// pending result; entries themselves are not cleared.
// length_now carries the low 7 bits of the length.

`include "indexed_list_store_top_assert.svh"

module indexed_list_store_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  ils_req_if.sink        req,
  ils_rsp_if.source      rsp
);

  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  localparam logic [ils_pkg::SLOT_W-1:0] CAP_SLOT = ils_pkg::SLOT_W'(CAPACITY);

  ils_pkg::fsm_state_t state, state_next;
  ils_pkg::cell_ctrl_t ctrl;

  logic [LEN_W-1:0] length, length_next;

  logic                              out_valid, out_valid_next;
  logic signed [ils_pkg::DATA_W-1:0] out_rd, out_rd_next;
  logic [1:0]                        out_st, out_st_next;
  logic [6:0]                        out_len, out_len_next;

  logic signed [ils_pkg::DATA_W-1:0] ent  [CAPACITY];
  logic signed [ils_pkg::DATA_W-1:0] gath [CAPACITY];
  logic signed [ils_pkg::DATA_W-1:0] gath_or;

  logic                        in_fire;
  logic [ils_pkg::SLOT_W-1:0]  len_slot, pos_slot, ins_slot;
  logic [LEN_W+6:0]            len_ext;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [ils_pkg::DATA_W-1:0] left_w, right_w;
      if (gi == 0) begin : g_first
        assign left_w = ent[gi];
      end else begin : g_left
        assign left_w = ent[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_w = ent[gi];
      end else begin : g_right
        assign right_w = ent[gi+1];
      end
      ils_cell #(.IDX(gi)) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .left     (left_w),
        .right    (right_w),
        .entry    (ent[gi]),
        .gathered (gath[gi])
      );
    end
  endgenerate

  always_comb begin
    gath_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      gath_or = gath_or | gath[i];
    end
  end

  assign req.ready = (state == ils_pkg::FSM_IDLE) && (!out_valid || rsp.ready);
  assign in_fire   = req.valid && req.ready;
  assign len_slot  = ils_pkg::SLOT_W'(length);
  assign pos_slot  = ils_pkg::SLOT_W'(req.position);
  assign len_ext   = {7'd0, length};

  always_comb begin
    case (req.action)
      ils_pkg::ACT_FRONT: ins_slot = '0;
      ils_pkg::ACT_BACK:  ins_slot = len_slot;
      default:            ins_slot = pos_slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ils_pkg::FSM_IDLE;
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      length    <= length_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_rd  <= out_rd_next;
    out_st  <= out_st_next;
    out_len <= out_len_next;
  end

  always_comb begin
    state_next     = state;
    length_next    = length;
    out_valid_next = out_valid && !rsp.ready;
    out_rd_next    = out_rd;
    out_st_next    = out_st;
    out_len_next   = out_len;
    ctrl.op        = ils_pkg::CELL_HOLD;
    ctrl.pos       = ins_slot;
    ctrl.value     = req.value;

    case (state)
      ils_pkg::FSM_IDLE: begin
        if (in_fire) begin
          out_valid_next = 1'b1;
          out_rd_next    = '0;
          out_st_next    = ils_pkg::ST_DONE;
          case (req.action)
            ils_pkg::ACT_READ: begin
              if (pos_slot < len_slot) begin
                // Gather the word first; the FSM_READ state then loads it into the result register.
                ctrl.op        = ils_pkg::CELL_GATHER;
                out_valid_next = 1'b0;
                state_next     = ils_pkg::FSM_READ;
              end else begin
                out_rd_next = ils_pkg::READ_MISS;
                out_st_next = ils_pkg::ST_RANGE;
              end
            end
            ils_pkg::ACT_FRONT, ils_pkg::ACT_BACK, ils_pkg::ACT_AT: begin
              if (ins_slot > len_slot) begin
                out_st_next = ils_pkg::ST_RANGE;
              end else if (len_slot >= CAP_SLOT) begin
                out_st_next = ils_pkg::ST_FULL;
              end else begin
                ctrl.op     = ils_pkg::CELL_INSERT;
                length_next = length + LEN_W'(1);
              end
            end
            ils_pkg::ACT_DELETE: begin
              if (pos_slot < len_slot) begin
                ctrl.op     = ils_pkg::CELL_DELETE;
                length_next = length - LEN_W'(1);
              end else begin
                out_st_next = ils_pkg::ST_RANGE;
              end
            end
            default: out_st_next = ils_pkg::ST_RANGE;
          endcase
          out_len_next = 7'(length_next);
        end
      end
      ils_pkg::FSM_READ: begin
        out_valid_next = 1'b1;
        out_rd_next    = gath_or;
        out_st_next    = ils_pkg::ST_DONE;
        out_len_next   = len_ext[6:0];
        state_next     = ils_pkg::FSM_IDLE;
      end
      default: state_next = ils_pkg::FSM_IDLE;
    endcase
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_rd;
  assign rsp.status     = out_st;
  assign rsp.length_now = out_len;

  `ILS_ASSERT(a_len_bound, ({1'b0, length} <= (LEN_W+1)'(CAPACITY)), "length above capacity")
  `ILS_ASSERT(a_read_slot_free, (state != ils_pkg::FSM_READ || !out_valid), "result slot busy in read")
  `ILS_ASSERT(a_full_len, (!out_valid || out_st != ils_pkg::ST_FULL || length == LEN_W'(CAPACITY)), "full status while not full")
  `ILS_ASSERT_NEXT(a_read_gather, (in_fire && req.action == ils_pkg::ACT_READ && pos_slot < len_slot), (state == ils_pkg::FSM_READ && !out_valid), "in-range read not gathered")

endmodule
